@@ design/rpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcd_pkg
// Shared types and constants of the RPC frame deframer: parse phases,
// field tags, frame status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcd_pkg;

    // fixed frame overhead: start, length, id len, method len, err, info len,
    // checksum, end
    localparam int unsigned HEADER_OVERHEAD = 26;

    // fixed bytes that still follow each length word
    localparam int unsigned FIXED_AFTER_IDLEN = 17;
    localparam int unsigned FIXED_AFTER_MLEN  = 13;
    localparam int unsigned FIXED_AFTER_ILEN  = 5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

    // reset values of the markers
    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] END_MARKER_RST   = 8'h03;

    // field tags
    typedef enum logic [3:0] {
        TAG_START   = 4'd0,
        TAG_LENGTH  = 4'd1,
        TAG_IDLEN   = 4'd2,
        TAG_ID      = 4'd3,
        TAG_MLEN    = 4'd4,
        TAG_METHOD  = 4'd5,
        TAG_ERR     = 4'd6,
        TAG_ILEN    = 4'd7,
        TAG_INFO    = 4'd8,
        TAG_PAYLOAD = 4'd9,
        TAG_CKSUM   = 4'd10,
        TAG_END     = 4'd11
    } t_tag;

    // frame status codes
    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD_END = 3'd2,
        ST_BAD_LEN = 3'd3,
        ST_OVERRUN = 3'd4
    } t_status;

    // parse phases, one-hot
    typedef enum logic [12:0] {
        PH_HUNT    = 13'b0000000000001,
        PH_LEN     = 13'b0000000000010,
        PH_IDLEN   = 13'b0000000000100,
        PH_ID      = 13'b0000000001000,
        PH_MLEN    = 13'b0000000010000,
        PH_METHOD  = 13'b0000000100000,
        PH_ERR     = 13'b0000001000000,
        PH_ILEN    = 13'b0000010000000,
        PH_INFO    = 13'b0000100000000,
        PH_PAYLOAD = 13'b0001000000000,
        PH_CKSUM   = 13'b0010000000000,
        PH_END     = 13'b0100000000000,
        PH_SKIP    = 13'b1000000000000
    } t_phase;

    // one result item
    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        t_tag        field_tag;
        logic        word_valid;
        logic [31:0] word_value;
        logic        frame_last;
        t_status     frame_status;
    } t_result;

    // tag carried by a byte taken in a given phase
    function automatic t_tag phase_tag(input t_phase ph);
        t_tag tag;
        unique case (ph)
            PH_LEN:     tag = TAG_LENGTH;
            PH_IDLEN:   tag = TAG_IDLEN;
            PH_ID:      tag = TAG_ID;
            PH_MLEN:    tag = TAG_MLEN;
            PH_METHOD:  tag = TAG_METHOD;
            PH_ERR:     tag = TAG_ERR;
            PH_ILEN:    tag = TAG_ILEN;
            PH_INFO:    tag = TAG_INFO;
            PH_PAYLOAD: tag = TAG_PAYLOAD;
            PH_CKSUM:   tag = TAG_CKSUM;
            PH_END:     tag = TAG_END;
            default:    tag = TAG_START;
        endcase
        return tag;
    endfunction

endpackage

`default_nettype wire

@@ design/rpcd_parser.sv @@
// ----------------------------------------------------------------------------
// rpcd_parser
// Frame parse state and the single-pass step logic: takes one byte when
// stepped, updates the phase, counters and word assembly, and presents the
// result of that byte in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcd_parser
    import rpcd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 65536
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_start_marker,
    input  wire logic [7:0] i_end_marker,
    output t_result         o_res
);

    // frame lengths and counts inside a frame fit in this width
    localparam int unsigned LW = $clog2(MAX_FRAME + 1);

    t_phase          r_phase, n_phase;
    logic [LW-1:0]   r_left,  n_left;    // frame bytes still to come, the current one included
    logic [LW-1:0]   r_rem,   n_rem;     // bytes left in a variable field or skip
    logic [31:0]     r_shift, n_shift;
    logic [1:0]      r_cnt,   n_cnt;

    logic [31:0]     word_next;
    logic [1:0]      cnt_next;
    logic [LW-1:0]   left_dec;
    logic [LW-1:0]   rem_dec;
    logic [LW-1:0]   fixed_after;
    logic [LW-1:0]   room;
    logic            overrun;
    t_result         res;

    // shared datapath pieces
    always_comb begin
        word_next = {r_shift[23:0], i_byte};
        cnt_next  = r_cnt + 2'd1;
        left_dec  = r_left - LW'(1);
        rem_dec   = (r_rem != '0) ? (r_rem - LW'(1)) : '0;
        case (r_phase)
            PH_IDLEN: fixed_after = LW'(FIXED_AFTER_IDLEN);
            PH_MLEN:  fixed_after = LW'(FIXED_AFTER_MLEN);
            default:  fixed_after = LW'(FIXED_AFTER_ILEN);
        endcase
        room    = left_dec - fixed_after;
        overrun = word_next > {{(32-LW){1'b0}}, room};
    end

    // next state and result of one byte
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        res              = '0;
        res.data_byte    = i_byte;
        res.field_tag    = phase_tag(r_phase);
        res.frame_status = ST_BUSY;
        if (i_step) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_start_marker) begin
                        res.valid     = 1'b1;
                        res.field_tag = TAG_START;
                        n_shift       = '0;
                        n_cnt         = '0;
                        n_phase       = PH_LEN;
                    end
                end
                PH_SKIP: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_END: begin
                    res.valid        = 1'b1;
                    res.frame_last   = 1'b1;
                    res.frame_status = (i_byte == i_end_marker) ? ST_OK : ST_BAD_END;
                    n_phase          = PH_HUNT;
                end
                PH_ID, PH_METHOD, PH_INFO, PH_PAYLOAD: begin
                    res.valid = 1'b1;
                    n_left    = left_dec;
                    n_rem     = rem_dec;
                    if (rem_dec == '0) begin
                        case (r_phase)
                            PH_ID:     n_phase = PH_MLEN;
                            PH_METHOD: n_phase = PH_ERR;
                            PH_INFO: begin
                                // payload takes what the frame leaves before checksum
                                n_rem   = left_dec - LW'(FIXED_AFTER_ILEN);
                                n_phase = (n_rem != '0) ? PH_PAYLOAD : PH_CKSUM;
                            end
                            default:   n_phase = PH_CKSUM;
                        endcase
                    end
                end
                PH_LEN, PH_IDLEN, PH_MLEN, PH_ERR, PH_ILEN, PH_CKSUM: begin
                    res.valid = 1'b1;
                    n_left    = left_dec;
                    n_shift   = word_next;
                    n_cnt     = cnt_next;
                    if (cnt_next == 2'd0) begin
                        res.word_valid = 1'b1;
                        res.word_value = word_next;
                        n_shift        = '0;
                        case (r_phase)
                            PH_LEN: begin
                                if (word_next < 32'(HEADER_OVERHEAD) ||
                                    word_next > 32'(MAX_FRAME)) begin
                                    res.frame_last   = 1'b1;
                                    res.frame_status = ST_BAD_LEN;
                                    n_phase          = PH_HUNT;
                                end else begin
                                    // five frame bytes are already in
                                    n_left  = word_next[LW-1:0] - LW'(5);
                                    n_phase = PH_IDLEN;
                                end
                            end
                            PH_IDLEN, PH_MLEN, PH_ILEN: begin
                                if (overrun) begin
                                    res.frame_last   = 1'b1;
                                    res.frame_status = ST_OVERRUN;
                                    n_rem            = left_dec;
                                    n_phase          = (left_dec != '0) ? PH_SKIP : PH_HUNT;
                                end else begin
                                    n_rem = word_next[LW-1:0];
                                    if (r_phase == PH_IDLEN) begin
                                        n_phase = (n_rem != '0) ? PH_ID : PH_MLEN;
                                    end else if (r_phase == PH_MLEN) begin
                                        n_phase = (n_rem != '0) ? PH_METHOD : PH_ERR;
                                    end else if (n_rem != '0) begin
                                        n_phase = PH_INFO;
                                    end else begin
                                        n_rem   = left_dec - LW'(FIXED_AFTER_ILEN);
                                        n_phase = (n_rem != '0) ? PH_PAYLOAD : PH_CKSUM;
                                    end
                                end
                            end
                            PH_ERR:  n_phase = PH_ILEN;
                            default: n_phase = PH_END;
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
            r_rem   <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_rem   <= n_rem;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

@@ design/rpc_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// rpc_frame_deframer_unit
// Streaming deframer for length-prefixed RPC frames with field tagging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_byte) takes one stream byte
//   per request. While hunting, bytes other than the start marker are dropped.
//   Every frame byte comes out on the output channel (o_out_valid /
//   i_out_stall) tagged with its field; the byte that closes a 32-bit header
//   word also carries the word. The last byte of a frame, or the byte that
//   aborts it, carries frame_last and a status. After a layout overrun the
//   rest of the frame is consumed without output.
//   A byte's result is registered and shows in the cycle after it is accepted.
//   Throughput: one byte per cycle unless the output stalls; the whole step
//   for a byte is one pass of the parser logic into the output register.
//   Stall: o_in_stall rises only while the output register holds a result
//   and i_out_stall is high; otherwise bytes keep flowing, also into a
//   waiting slot that is freed in the same cycle.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 writes
//   the start marker, index 1 the end marker, low 8 bits of the data; other
//   indexes are ignored. Write only while the block is idle.
//   Reset (synchronous, i_rst_n low): hunting, markers back to 2 and 3,
//   output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_frame_deframer_unit
    import rpcd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // byte input
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_in_byte,
    // result output
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_data_byte,
    output logic [3:0]                 o_field_tag,
    output logic                       o_word_valid,
    output logic signed [31:0]         o_word_value,
    output logic                       o_frame_last,
    output logic [2:0]                 o_frame_status,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       in_accept;
    logic       out_free;
    t_result    res;

    // handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !out_free;
    assign in_accept   = i_in_valid && out_free;
    assign o_cfg_ready = 1'b1;

    // parser
    rpcd_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_byte         (i_in_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_res          (res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data[7:0];
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_accept && res.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_free && in_accept && res.valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_out.data_byte;
    assign o_field_tag    = r_out.field_tag;
    assign o_word_valid   = r_out.word_valid;
    assign o_word_value   = $signed(r_out.word_value);
    assign o_frame_last   = r_out.frame_last;
    assign o_frame_status = r_out.frame_status;

`ifndef NO_ASSERTIONS
    // a status is given exactly on the last byte of a frame
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_last == (o_frame_status != ST_BUSY)))
        else $error("frame status and frame_last disagree");

    // words come only from header word fields
    a_word_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_word_valid) |->
            (o_field_tag == TAG_LENGTH || o_field_tag == TAG_IDLEN ||
             o_field_tag == TAG_MLEN || o_field_tag == TAG_ERR ||
             o_field_tag == TAG_ILEN || o_field_tag == TAG_CKSUM))
        else $error("word given on a non-word field");

    // end marker checks are reported only on the end byte
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_frame_status == ST_OK || o_frame_status == ST_BAD_END)) |->
            (o_field_tag == TAG_END))
        else $error("end status outside the end byte");

    // length and overrun aborts come with the word that caused them
    a_abort_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_frame_status == ST_BAD_LEN || o_frame_status == ST_OVERRUN))
            |-> o_word_valid)
        else $error("abort without its length word");

    // word value is zero unless a word is given
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_word_valid) |-> (o_word_value == 32'sd0))
        else $error("stray word value");
`endif

endmodule

`default_nettype wire
